[rtl/alcr_pkg.sv]
// Shared types, constants and helpers for the ASCII line checksum receiver.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package alcr_pkg;

  // Longest line, in received bytes, before it is cut off.
  localparam int unsigned MAX_LINE = 128;

  // Results one input beat can cause, and the result queue that holds them.
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = CFG_IDX_W'(1);

  // Register reset values.
  localparam logic [7:0] END_CHAR_RESET     = 8'h0D;
  localparam logic       CHECK_ENABLE_RESET = 1'b1;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } out_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_DATA   = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_TOO_SHORT = 3'd3,
    ST_BAD_SUM   = 3'd4
  } line_status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       no_data;
  } in_beat_t;

  typedef struct packed {
    out_kind_t    out_kind;
    logic [7:0]   out_byte;
    line_status_t line_status;
    logic [7:0]   line_length;
    logic         is_last;
  } out_beat_t;

  // {valid, nibble} for one hex digit character.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

[rtl/ascii_line_checksum_receiver_unit.sv]
// Top level of the ASCII line checksum receiver: line assembly, hex checksum
// verdict and a small result queue. Depends on alcr_pkg.
`timescale 1ns / 1ps

// Channel   Dir   Payload                      Handshake
// in_       in    alcr_pkg::in_beat_t          in_valid / in_ready
// out_      out   alcr_pkg::out_beat_t         out_valid / out_ready
// cfg_      in    index (2b) + data (8b)       cfg_valid / cfg_ready (always 1)
//
// One input beat per cycle; its 0..3 result beats enter a 4-deep queue at once
// and are visible the next cycle. The queue drains one beat per cycle while
// out_ready is high. in_ready is high while the queue holds at most one beat,
// so a beat with two or three results stalls input until the queue drains to
// one beat, longer while out_ready is low. Synchronous reset empties the queue,
// restarts the line, loads end_char = CR and check_enable = 1; no clearing pass.

module ascii_line_checksum_receiver_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  alcr_pkg::in_beat_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output alcr_pkg::out_beat_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [alcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data
);

  localparam int unsigned AW = alcr_pkg::FIFO_AW;
  localparam int unsigned CW = alcr_pkg::FIFO_CW;

  // Configuration registers
  logic [7:0] end_char_r;
  logic       check_enable_r;

  // Line state
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] held0_r, held0_nxt;   // older held byte
  logic [7:0] held1_r, held1_nxt;   // newest held byte

  // Result queue
  alcr_pkg::out_beat_t fifo_r [alcr_pkg::FIFO_DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r, count_nxt;

  // Results of the current input beat
  alcr_pkg::out_beat_t res [alcr_pkg::MAX_RESULTS];
  logic [1:0] nres;

  logic       in_fire, out_fire;
  logic [7:0] c;
  logic       hit_end;
  logic       too_long;
  logic [7:0] payload_sum;
  logic [4:0] hex_hi, hex_lo;
  logic       sum_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count_r <= CW'(alcr_pkg::FIFO_DEPTH - alcr_pkg::MAX_RESULTS));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = fifo_r[rptr_r];

  assign c        = in_data.rx_byte;
  assign hit_end  = (c == end_char_r);
  // The byte that brings the count to the limit closes the line.
  assign too_long = ({1'b0, byte_count_r} + 9'd1) >= 9'(alcr_pkg::MAX_LINE);

  assign payload_sum = running_sum_r - held0_r - held1_r;
  assign hex_hi      = alcr_pkg::hex_digit(held0_r);
  assign hex_lo      = alcr_pkg::hex_digit(held1_r);
  assign sum_ok      = hex_hi[4] && hex_lo[4] && ({hex_hi[3:0], hex_lo[3:0]} == payload_sum);

  // Decode one input beat into its results and the next line state.
  always_comb begin
    for (int k = 0; k < alcr_pkg::MAX_RESULTS; k++) begin
      res[k] = '{out_kind: alcr_pkg::KIND_DATA, out_byte: 8'h00,
                 line_status: alcr_pkg::ST_OK, line_length: 8'h00, is_last: 1'b0};
    end
    nres            = 2'd0;
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    held0_nxt       = held0_r;
    held1_nxt       = held1_r;

    if (in_data.no_data || hit_end || too_long) begin
      // Line closes: flush held bytes where required, then the status beat.
      // An end character wins over the length limit.
      if (check_enable_r && (in_data.no_data || (!hit_end && too_long) ||
                             (hit_end && byte_count_r < 8'd2))) begin
        if (byte_count_r >= 8'd2) begin
          res[nres].out_byte = held0_r;
          nres = nres + 2'd1;
        end
        if (byte_count_r >= 8'd1) begin
          res[nres].out_byte = held1_r;
          nres = nres + 2'd1;
        end
      end
      res[nres].out_kind    = alcr_pkg::KIND_STATUS;
      res[nres].line_length = byte_count_r;
      priority if (in_data.no_data) begin
        res[nres].line_status = alcr_pkg::ST_NO_DATA;
      end else if (hit_end) begin
        if (!check_enable_r) begin
          res[nres].line_status = alcr_pkg::ST_OK;
        end else if (byte_count_r < 8'd2) begin
          res[nres].line_status = alcr_pkg::ST_TOO_SHORT;
        end else begin
          res[nres].line_status = sum_ok ? alcr_pkg::ST_OK : alcr_pkg::ST_BAD_SUM;
          res[nres].line_length = byte_count_r - 8'd2;
        end
      end else begin
        res[nres].line_status = alcr_pkg::ST_TOO_LONG;
        res[nres].out_byte    = c;
        res[nres].line_length = byte_count_r + 8'd1;
      end
      nres            = nres + 2'd1;
      byte_count_nxt  = 8'h00;
      running_sum_nxt = 8'h00;
      held0_nxt       = 8'h00;
      held1_nxt       = 8'h00;
    end else begin
      // Ordinary byte: with checking on, release the byte two places back.
      if (check_enable_r) begin
        if (byte_count_r >= 8'd2) begin
          res[0].out_byte = held0_r;
          nres = 2'd1;
        end
      end else begin
        res[0].out_byte = c;
        nres = 2'd1;
      end
      held0_nxt       = held1_r;
      held1_nxt       = c;
      byte_count_nxt  = byte_count_r + 8'd1;
      running_sum_nxt = running_sum_r + c;
    end

    if (nres != 2'd0) begin
      res[nres - 2'd1].is_last = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_fire) begin
      count_nxt = count_nxt + CW'(nres);
    end
    if (out_fire) begin
      count_nxt = count_nxt - CW'(1);
    end
  end

  // Control and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_char_r     <= alcr_pkg::END_CHAR_RESET;
      check_enable_r <= alcr_pkg::CHECK_ENABLE_RESET;
      byte_count_r   <= 8'h00;
      running_sum_r  <= 8'h00;
      held0_r        <= 8'h00;
      held1_r        <= 8'h00;
      wptr_r         <= '0;
      rptr_r         <= '0;
      count_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          alcr_pkg::CFG_END_CHAR:     end_char_r     <= cfg_data;
          alcr_pkg::CFG_CHECK_ENABLE: check_enable_r <= cfg_data[0];
          default: ;  // unknown index: ignored
        endcase
      end
      if (in_fire) begin
        byte_count_r  <= byte_count_nxt;
        running_sum_r <= running_sum_nxt;
        held0_r       <= held0_nxt;
        held1_r       <= held1_nxt;
        wptr_r        <= wptr_r + AW'(nres);
      end
      if (out_fire) begin
        rptr_r <= rptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < alcr_pkg::MAX_RESULTS; k++) begin
        if (k < int'(nres)) begin
          fifo_r[wptr_r + AW'(k)] <= res[k];
        end
      end
    end
  end

endmodule

[rtl/alcr_checker.sv]
// Port-level checks for the ASCII line checksum receiver, bound to the top.
// Depends on alcr_pkg.
`timescale 1ns / 1ps

module alcr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input alcr_pkg::out_beat_t out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A status beat always closes the results of its input beat.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == alcr_pkg::KIND_STATUS |-> out_data.is_last)
    else $error("status beat without is_last");

  // Payload beats carry no status or length.
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == alcr_pkg::KIND_DATA |->
      out_data.line_status == alcr_pkg::ST_OK && out_data.line_length == 8'h00)
    else $error("payload beat with status fields set");

  // An overlong line reports exactly the limit; others stay below it.
  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == alcr_pkg::KIND_STATUS |->
      (out_data.line_status == alcr_pkg::ST_TOO_LONG) ==
      (out_data.line_length == 8'(alcr_pkg::MAX_LINE)))
    else $error("line length inconsistent with too-long status");

endmodule

bind ascii_line_checksum_receiver_unit alcr_checker u_alcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
